// ===== design/i2cm_pkg.sv =====
// Shared types and codes for the I2C master byte engine.
package i2cm_pkg;

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [2:0] {
        K_TICK,
        K_START,
        K_STOP,
        K_WRITE,
        K_READ
    } t_kind;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       master_nack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       slave_nack;
        logic       cmd_rejected;
    } t_result;

    // Classified item as it travels from the front to the engine.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx_byte;
        logic       master_nack;
        logic       sda_in;
    } t_work;

    typedef struct packed {
        logic  valid;
        t_work work;
    } t_work_port;

endpackage

// ===== design/i2cm_front.sv =====
// Front end: classify the incoming action code into a work kind.
module i2cm_front (
    input  i2cm_pkg::t_in_item i_item,
    output i2cm_pkg::t_work    o_work
);

    i2cm_pkg::t_kind kind;

    always_comb begin
        case (i_item.action)
            i2cm_pkg::ACT_START: kind = i2cm_pkg::K_START;
            i2cm_pkg::ACT_STOP:  kind = i2cm_pkg::K_STOP;
            i2cm_pkg::ACT_WRITE: kind = i2cm_pkg::K_WRITE;
            i2cm_pkg::ACT_READ:  kind = i2cm_pkg::K_READ;
            // plain tick and unused codes advance the engine
            default:             kind = i2cm_pkg::K_TICK;
        endcase
    end

    assign o_work.kind        = kind;
    assign o_work.tx_byte     = i_item.tx_byte;
    assign o_work.master_nack = i_item.master_nack;
    assign o_work.sda_in      = i_item.sda_in;

endmodule

// ===== design/i2cm_queue.sv =====
// Short queue of classified items between front end and engine.
module i2cm_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  i2cm_pkg::t_work        i_work,
    output logic                   o_full,
    output i2cm_pkg::t_work_port   o_head,
    input  logic                   i_pop
);

    localparam int unsigned AW = i2cm_pkg::QUEUE_AW;

    i2cm_pkg::t_work r_mem [i2cm_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW:0]   r_count,  n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(i2cm_pkg::QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.work  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== design/i2cm_engine.sv =====
// Back end: SCL/SDA phase sequencer with a registered result stage.
module i2cm_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cm_pkg::t_work_port i_head,
    output logic                 o_take,
    output logic                 o_empty,
    output i2cm_pkg::t_result    o_result,
    input  logic                 i_pop
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2, PH_SP3,
        PH_W_HI, PH_W_LO, PH_WA_HI, PH_WA_SMP, PH_WA_END,
        PH_R_HI, PH_R_SMP, PH_R_LO, PH_RA_HI, PH_RA_LO, PH_RA_END
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [3:0]        r_bit_count, n_bit_count;
    logic [7:0]        r_shift, n_shift;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_ack_choice, n_ack_choice;
    logic              r_nack_flag, n_nack_flag;
    logic [7:0]        r_rx_hold, n_rx_hold;
    logic              r_out_valid, n_out_valid;
    i2cm_pkg::t_result r_out, n_out;

    logic       done;
    logic       rejected;
    logic [7:0] shifted;
    logic [3:0] count_inc;

    i2cm_pkg::t_work w;

    assign w        = i_head.work;
    // Take the next item whenever the result stage is free or drains this cycle.
    assign o_take   = i_head.valid && (!r_out_valid || i_pop);
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    assign shifted   = {r_shift[6:0], 1'b0};
    assign count_inc = r_bit_count + 4'd1;

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_choice = r_ack_choice;
        n_nack_flag  = r_nack_flag;
        n_rx_hold    = r_rx_hold;
        done         = 1'b0;
        rejected     = 1'b0;

        if (w.kind != i2cm_pkg::K_TICK) begin
            if (r_phase != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                case (w.kind)
                    i2cm_pkg::K_START: begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_phase = PH_ST1;
                    end
                    i2cm_pkg::K_STOP: begin
                        n_sda   = 1'b0;
                        n_phase = PH_SP1;
                    end
                    i2cm_pkg::K_WRITE: begin
                        n_shift     = w.tx_byte;
                        n_bit_count = '0;
                        n_sda       = w.tx_byte[7];
                        n_phase     = PH_W_HI;
                    end
                    default: begin
                        n_ack_choice = w.master_nack;
                        n_shift      = '0;
                        n_bit_count  = '0;
                        n_sda        = 1'b1;
                        n_phase      = PH_R_HI;
                    end
                endcase
            end
        end else begin
            case (r_phase)
                PH_ST1:  begin n_sda = 1'b0; n_phase = PH_ST2; end
                PH_ST2:  begin n_scl = 1'b0; n_phase = PH_ST3; end
                PH_SP1:  begin n_scl = 1'b1; n_phase = PH_SP2; end
                PH_SP2:  begin n_sda = 1'b1; n_phase = PH_SP3; end
                PH_W_HI: begin n_scl = 1'b1; n_phase = PH_W_LO; end
                PH_W_LO: begin
                    n_scl       = 1'b0;
                    n_shift     = shifted;
                    n_bit_count = count_inc;
                    if (count_inc < i2cm_pkg::BITS_PER_BYTE) begin
                        n_sda   = shifted[7];
                        n_phase = PH_W_HI;
                    end else begin
                        // release SDA for the slave acknowledge
                        n_sda   = 1'b1;
                        n_phase = PH_WA_HI;
                    end
                end
                PH_WA_HI: begin n_scl = 1'b1; n_phase = PH_WA_SMP; end
                PH_WA_SMP: begin
                    n_nack_flag = w.sda_in;
                    n_scl       = 1'b0;
                    n_phase     = PH_WA_END;
                end
                PH_R_HI: begin n_scl = 1'b1; n_phase = PH_R_SMP; end
                PH_R_SMP: begin
                    n_shift     = {r_shift[6:0], w.sda_in};
                    n_bit_count = count_inc;
                    n_scl       = 1'b0;
                    n_phase     = PH_R_LO;
                end
                PH_R_LO: begin
                    if (r_bit_count < i2cm_pkg::BITS_PER_BYTE) begin
                        n_scl   = 1'b1;
                        n_phase = PH_R_SMP;
                    end else begin
                        n_sda   = r_ack_choice;
                        n_phase = PH_RA_HI;
                    end
                end
                PH_RA_HI: begin n_scl = 1'b1; n_phase = PH_RA_LO; end
                PH_RA_LO: begin
                    n_scl   = 1'b0;
                    n_sda   = 1'b1;
                    n_phase = PH_RA_END;
                end
                PH_RA_END: begin
                    n_rx_hold = r_shift;
                    n_phase   = PH_IDLE;
                    done      = 1'b1;
                end
                PH_ST3, PH_SP3, PH_WA_END: begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        n_out.scl_out      = n_scl;
        n_out.sda_out      = n_sda;
        n_out.busy_res     = (n_phase != PH_IDLE);
        n_out.done_res     = done;
        n_out.rx_byte      = n_rx_hold;
        n_out.slave_nack   = n_nack_flag;
        n_out.cmd_rejected = rejected;

        n_out_valid = o_take ? 1'b1 : (i_pop ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack_choice <= 1'b0;
            r_nack_flag  <= 1'b0;
            r_rx_hold    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_phase      <= n_phase;
                r_bit_count  <= n_bit_count;
                r_shift      <= n_shift;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_ack_choice <= n_ack_choice;
                r_nack_flag  <= n_nack_flag;
                r_rx_hold    <= n_rx_hold;
            end
        end
        if (o_take) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== design/i2c_master_byte_engine.sv =====
// An accepted item is written into the item queue and then registered into the result stage.
// Throughput: one item per cycle while results are popped; the phase sequencer takes a queued item
// when the result stage is free or drains; a four-entry item queue lets the input side run on while results wait.
// Reset (synchronous, active low): SCL and SDA released, engine idle, held bytes and
// flags cleared, item queue and result stage emptied.
module i2c_master_byte_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  i2cm_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output i2cm_pkg::t_result   o_result
);

    i2cm_pkg::t_work      work;
    i2cm_pkg::t_work_port head;
    logic                 take;

    i2cm_front u_front (
        .i_item (i_item),
        .o_work (work)
    );

    i2cm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (work),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (take)
    );

    i2cm_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_take   (take),
        .o_empty  (empty),
        .o_result (o_result),
        .i_pop    (pop)
    );

endmodule
